>>> sv/pba_pkg.sv
// shared types and codes for the page bitmap allocator
package pba_pkg;

	// operation codes
	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_RESERVE = 2'd2,
		OP_RELEASE = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NOSPACE  = 3'd1,
		ST_MISALIGN = 3'd2,
		ST_BADPAGE  = 3'd3,
		ST_ZERO     = 3'd4
	} status_t;

	// request beat
	typedef struct packed {
		op_t         op;
		logic [31:0] addr;
		logic [31:0] end_addr;
		logic [15:0] page_count;
	} req_t;

	// response beat
	typedef struct packed {
		status_t     status;
		logic [26:0] block_addr;
		logic [15:0] free_pages;
	} rsp_t;

	// run finder control
	typedef struct packed {
		logic restart;
		logic step;
	} scan_ctl_t;

endpackage

>>> sv/page_bitmap_allocator_unit.sv
// page bitmap allocator top level: control, range sweeps and next-fit scan
//
// channel | dir | handshake             | beat
// req     | in  | req_valid / req_ready | pba_pkg::req_t
// rsp     | out | rsp_valid / rsp_ready | pba_pkg::rsp_t
//
// after reset the bitmap is filled with ones, one word a cycle, while req_ready
// stays low.
// one request at a time; bitmap accessed one 32-bit word per cycle.
// allocate: one or two scans of the word range plus a set pass over the words
// of the marked run; free: check pass plus clear pass.
// reserve/release: one set or clear pass over the words touched.
// a pending response does not block the next request; the response
// register must be free before a finished request leaves its last state.
module page_bitmap_allocator_unit #(
	parameter int NUM_PAGES  = 32768,
	parameter int PAGE_BYTES = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  pba_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output pba_pkg::rsp_t  rsp
);
	import pba_pkg::*;

	localparam int MAP_WORDS = (NUM_PAGES + 31) / 32;
	localparam int WW  = $clog2(MAP_WORDS);
	localparam int WX  = WW + 1;
	localparam int PG  = WW + 5;
	localparam int PGX = PG + 1;
	localparam int RW  = PG + 2;
	localparam int OFF = $clog2(PAGE_BYTES);
	localparam logic [34:0] NP35  = 35'(NUM_PAGES);
	localparam logic [WX-1:0] LASTW = WX'(MAP_WORDS - 1);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_DECODE, S_SCAN, S_SWEEP, S_DONE
	} state_t;

	typedef enum logic [1:0] {
		M_CHECK, M_SET, M_CLEAR
	} mode_t;

	state_t          state_q;
	mode_t           mode_q;
	req_t            req_q;
	status_t         status_q;
	logic [26:0]     blk_q;
	logic [PGX-1:0]  free_q;
	logic [PG-1:0]   search_q;
	logic [PG-1:0]   scan_from_q;
	logic            pass_b_q;
	logic [PGX-1:0]  lo_q;
	logic [PGX-1:0]  hi_q;
	logic [WX-1:0]   rd_w_q;
	logic [WX-1:0]   rd_end_q;
	logic [WW-1:0]   clr_w_q;
	logic            valid_s1;
	logic [WW-1:0]   w_s1;
	logic            rsp_valid_q;
	rsp_t            rsp_q;

	logic [31:0]     mem_rdata;
	logic            mem_we;
	logic [WW-1:0]   mem_waddr;
	logic [31:0]     mem_wdata;
	logic            rd_issue;
	logic            leave;
	logic            rsp_load;

	logic [15:0]     cnt;
	logic [34:0]     first35;
	logic [34:0]     endr35;
	logic [34:0]     last35;
	logic [34:0]     free_hi35;
	logic [PGX-1:0]  dec_lo;
	logic [PGX-1:0]  dec_hi;
	logic [PGX-1:0]  dec_hi_m1;

	logic [31:0]     scan_word;
	scan_ctl_t       scan_ctl;
	logic            hit;
	logic [4:0]      hit_bit;
	logic [PG-1:0]   end_pg;
	logic [PGX-1:0]  end_p1;
	logic [PGX-1:0]  start_pg;
	logic [PG+OFF+26:0] ba_wide;
	logic            scan_last;

	logic [PGX-1:0]  hi_m1;
	logic [31:0]     lo_mask;
	logic [31:0]     hi_mask;
	logic [31:0]     rng_mask;
	logic            chk_bad;
	logic [5:0]      flips;
	logic            sweep_wr;
	logic            sweep_last;

	// request decode arithmetic
	always_comb begin
		cnt       = req_q.page_count;
		first35   = 35'(req_q.addr >> OFF);
		endr35    = (35'(req_q.end_addr) + 35'(PAGE_BYTES - 1)) >> OFF;
		last35    = (endr35 > NP35) ? NP35 : endr35;
		free_hi35 = first35 + 35'(cnt);
		dec_lo    = first35[PGX-1:0];
		dec_hi    = (req_q.op == OP_FREE) ? free_hi35[PGX-1:0] : last35[PGX-1:0];
		dec_hi_m1 = dec_hi - PGX'(1);
	end

	// scan word: pages below the start position count as used
	always_comb begin
		scan_last = (WX'(w_s1) == LASTW);
		scan_word = mem_rdata;
		if (w_s1 == scan_from_q[PG-1:5]) begin
			scan_word = mem_rdata | ((32'd1 << scan_from_q[4:0]) - 32'd1);
		end
		scan_ctl.restart = (state_q == S_DECODE) || (state_q == S_SCAN && valid_s1 && !hit
			&& scan_last);
		scan_ctl.step    = (state_q == S_SCAN) && valid_s1 && !hit;
		end_pg    = {w_s1, hit_bit};
		end_p1    = PGX'(end_pg) + PGX'(1);
		start_pg  = end_p1 - PGX'(cnt);
		ba_wide   = (PG + OFF + 27)'(start_pg) << OFF;
	end

	pba_run_find #(.RW(RW)) u_find (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (scan_ctl),
		.word    (scan_word),
		.need    (RW'(cnt)),
		.hit     (hit),
		.hit_bit (hit_bit)
	);

	// range mask and flip count for sweeps
	always_comb begin
		hi_m1    = hi_q - PGX'(1);
		lo_mask  = (w_s1 == lo_q[PG-1:5]) ? (32'hFFFF_FFFF << lo_q[4:0]) : 32'hFFFF_FFFF;
		hi_mask  = (w_s1 == hi_m1[PG-1:5]) ? (32'hFFFF_FFFF >> (5'd31 - hi_m1[4:0]))
			: 32'hFFFF_FFFF;
		rng_mask = lo_mask & hi_mask;
		chk_bad  = (mem_rdata & rng_mask) != rng_mask;
		if (mode_q == M_SET) begin
			flips = 6'($countones(rng_mask & ~mem_rdata));
		end else begin
			flips = 6'($countones(rng_mask & mem_rdata));
		end
		sweep_wr   = (state_q == S_SWEEP) && valid_s1 && (mode_q != M_CHECK);
		sweep_last = (WX'(w_s1) == rd_end_q);
	end

	// read issue and pass exit
	always_comb begin
		rd_issue = ((state_q == S_SCAN) || (state_q == S_SWEEP)) && (rd_w_q <= rd_end_q);
		leave    = 1'b0;
		if (state_q == S_SCAN && valid_s1) begin
			leave = hit || scan_last;
		end else if (state_q == S_SWEEP && valid_s1) begin
			leave = ((mode_q == M_CHECK) && chk_bad) || sweep_last;
		end
		rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);
	end

	// memory write port: clearing pass or sweep write-back
	always_comb begin
		mem_we    = (state_q == S_CLEAR) || sweep_wr;
		mem_waddr = (state_q == S_CLEAR) ? clr_w_q : w_s1;
		if (state_q == S_CLEAR) begin
			mem_wdata = 32'hFFFF_FFFF;
		end else if (mode_q == M_SET) begin
			mem_wdata = mem_rdata | rng_mask;
		end else begin
			mem_wdata = mem_rdata & ~rng_mask;
		end
	end

	pba_map_mem #(.WORDS(MAP_WORDS), .AW(WW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (rd_w_q[WW-1:0]),
		.rdata (mem_rdata)
	);

	// control state machine and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_w_q     <= '0;
			valid_s1    <= 1'b0;
			free_q      <= '0;
			search_q    <= '0;
			rsp_valid_q <= 1'b0;
			rd_w_q      <= '0;
			rd_end_q    <= '0;
			pass_b_q    <= 1'b0;
			mode_q      <= M_CHECK;
		end else begin
			valid_s1 <= rd_issue && !leave;
			w_s1     <= rd_w_q[WW-1:0];
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_w_q <= clr_w_q + WW'(1);
					if (WX'(clr_w_q) == LASTW) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					blk_q    <= '0;
					lo_q     <= dec_lo;
					hi_q     <= dec_hi;
					unique case (req_q.op)
						OP_ALLOC: begin
							if (cnt == 16'd0) begin
								status_q <= ST_ZERO;
								state_q  <= S_DONE;
							end else if (35'(free_q) <= 35'(cnt) || 35'(cnt) > NP35) begin
								status_q <= ST_NOSPACE;
								state_q  <= S_DONE;
							end else begin
								status_q    <= ST_OK;
								scan_from_q <= search_q;
								rd_w_q      <= WX'(search_q[PG-1:5]);
								rd_end_q    <= LASTW;
								pass_b_q    <= 1'b0;
								state_q     <= S_SCAN;
							end
						end
						OP_FREE: begin
							if (cnt == 16'd0) begin
								status_q <= ST_ZERO;
								state_q  <= S_DONE;
							end else if (req_q.addr[OFF-1:0] != '0) begin
								status_q <= ST_MISALIGN;
								state_q  <= S_DONE;
							end else if (free_hi35 > NP35) begin
								status_q <= ST_BADPAGE;
								state_q  <= S_DONE;
							end else begin
								status_q <= ST_OK;
								rd_w_q   <= WX'(dec_lo[PG-1:5]);
								rd_end_q <= WX'(dec_hi_m1[PG-1:5]);
								mode_q   <= M_CHECK;
								state_q  <= S_SWEEP;
							end
						end
						default: begin
							status_q <= ST_OK;
							if (first35 >= last35) begin
								state_q <= S_DONE;
							end else begin
								rd_w_q   <= WX'(dec_lo[PG-1:5]);
								rd_end_q <= WX'(dec_hi_m1[PG-1:5]);
								mode_q   <= (req_q.op == OP_RESERVE) ? M_SET : M_CLEAR;
								state_q  <= S_SWEEP;
							end
						end
					endcase
				end
				S_SCAN: begin
					if (valid_s1 && hit) begin
						// run found: mark it and move the next-fit position
						lo_q     <= start_pg;
						hi_q     <= end_p1;
						rd_w_q   <= WX'(start_pg[PG-1:5]);
						rd_end_q <= WX'(w_s1);
						mode_q   <= M_SET;
						blk_q    <= ba_wide[26:0];
						search_q <= (end_p1 == PGX'(NUM_PAGES)) ? '0 : end_p1[PG-1:0];
						state_q  <= S_SWEEP;
					end else if (valid_s1 && scan_last) begin
						if (!pass_b_q) begin
							// wrap: second pass from page zero
							pass_b_q    <= 1'b1;
							scan_from_q <= '0;
							rd_w_q      <= '0;
						end else begin
							status_q <= ST_NOSPACE;
							state_q  <= S_DONE;
						end
					end else if (rd_issue) begin
						rd_w_q <= rd_w_q + WX'(1);
					end
				end
				S_SWEEP: begin
					if (sweep_wr) begin
						if (mode_q == M_SET) begin
							free_q <= free_q - PGX'(flips);
						end else begin
							free_q <= free_q + PGX'(flips);
						end
					end
					if (valid_s1 && mode_q == M_CHECK && chk_bad) begin
						status_q <= ST_BADPAGE;
						state_q  <= S_DONE;
					end else if (valid_s1 && sweep_last) begin
						if (mode_q == M_CHECK) begin
							// every page in use: clear them
							mode_q <= M_CLEAR;
							rd_w_q <= WX'(lo_q[PG-1:5]);
						end else begin
							state_q <= S_DONE;
						end
					end else if (rd_issue) begin
						rd_w_q <= rd_w_q + WX'(1);
					end
				end
				S_DONE: begin
					if (rsp_load) begin
						rsp_q.status     <= status_q;
						rsp_q.block_addr <= blk_q;
						rsp_q.free_pages <= 16'(free_q);
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// no bitmap write while a new request can be taken
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !mem_we)
		else $error("bitmap written while idle");

	// free count never exceeds the page count
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= PGX'(NUM_PAGES))
		else $error("free count out of range");

	// next-fit position stays inside the bitmap
	a_search_range: assert property (@(posedge clk) disable iff (!arst_n)
		PGX'(search_q) < PGX'(NUM_PAGES))
		else $error("search position out of range");

	// read data is only consumed in the cycle after an issued read
	a_s1_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $past(rd_issue))
		else $error("stage one valid without a read");
endmodule

>>> sv/pba_map_mem.sv
// used-page bitmap memory, one write and one registered read port
module pba_map_mem #(
	parameter int WORDS = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);
	logic [31:0] mem [WORDS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

>>> sv/pba_run_find.sv
// clear-run finder over one bitmap word with a carried run length
module pba_run_find #(
	parameter int RW = 17
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pba_pkg::scan_ctl_t  ctl,
	input  logic [31:0]         word,
	input  logic [RW-1:0]       need,
	output logic                hit,
	output logic [4:0]          hit_bit
);
	import pba_pkg::*;

	logic [RW-1:0] run_q;
	logic [RW-1:0] run_next;
	logic [31:0]   seen_b;
	logic [4:0]    last_b [32];
	logic [31:0]   hit_vec;
	logic [RW-1:0] run_end;

	// per bit: last used bit at or below it, and the clear run ending there
	always_comb begin
		hit_vec = '0;
		run_end = '0;
		for (int b = 0; b < 32; b++) begin
			seen_b[b] = 1'b0;
			last_b[b] = '0;
			for (int j = 0; j < 32; j++) begin
				if (j <= b && word[j]) begin
					seen_b[b] = 1'b1;
					last_b[b] = 5'(j);
				end
			end
			if (seen_b[b]) begin
				run_end = RW'(5'(b) - last_b[b]);
			end else begin
				run_end = run_q + RW'(b + 1);
			end
			hit_vec[b] = (run_end >= need);
		end
	end

	// lowest bit where the run reaches the need
	always_comb begin
		hit     = |hit_vec;
		hit_bit = '0;
		for (int b = 31; b >= 0; b--) begin
			if (hit_vec[b]) begin
				hit_bit = 5'(b);
			end
		end
		run_next = seen_b[31] ? RW'(5'd31 - last_b[31]) : run_q + RW'(32);
	end

	// carried run length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (ctl.restart) begin
			run_q <= '0;
		end else if (ctl.step) begin
			run_q <= run_next;
		end
	end
endmodule
